@@ src/ffea_pkg.sv @@
package ffea_pkg;

    localparam int FREE_EXTENTS = 32;
    localparam int LIVE_BLOCKS  = 64;
    localparam int EXT_IDX_W    = $clog2(FREE_EXTENTS);
    localparam int EXT_CNT_W    = $clog2(FREE_EXTENTS + 1);
    localparam int LIVE_IDX_W   = $clog2(LIVE_BLOCKS);
    localparam int LIVE_CNT_W   = $clog2(LIVE_BLOCKS + 1);

    localparam logic [32:0] POOL_MAX   = 33'h1_0000_0000;
    localparam logic [32:0] GRAIN_MASK = 33'd255;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_UNKNOWN   = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam logic       CMD_ALLOC = 1'b0;
    localparam logic       CMD_FREE  = 1'b1;

    localparam logic       REG_POOL_BASE = 1'b0;
    localparam logic       REG_POOL_SIZE = 1'b1;

    typedef struct packed {
        logic        command;
        logic [31:0] request_bytes;
        logic [47:0] block_address;
    } ffea_in_t;

    typedef struct packed {
        logic [47:0] granted_address;
        logic [1:0]  status;
    } ffea_out_t;

    // one free extent as held by a cell
    typedef struct packed {
        logic [32:0] offset;
        logic [32:0] length;
    } ffea_ext_t;

endpackage

@@ src/first_fit_extent_allocator.sv @@
// First-fit extent allocator with coalescing, one request at a time.
// Allocate: scan the extents for the first that fits (none fits: exhausted), then scan the
// live table for a free slot, then record the block and trim or drop the extent.
// Free: an offset outside the pool range is answered without a scan; else scan the live
// table (unknown address: answered after that scan), then find the extent position and merge.
// The next request is taken the cycle after the result leaves. Reset (rst_n low,
// asynchronous) leaves pool size 0, no extents, no live blocks.
module first_fit_extent_allocator
    import ffea_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  ffea_in_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output ffea_out_t   out_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [47:0] cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LIVE  = 3'd1;
    localparam logic [2:0] S_EXT   = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [47:0]           base_reg;
    logic [EXT_CNT_W-1:0]  count_reg, count_next;
    logic                  cmd_reg;
    logic [32:0]           size_reg;
    logic [32:0]           off_reg, off_next;
    logic [32:0]           len_reg, len_next;
    logic [LIVE_CNT_W-1:0] lscan_reg, lscan_next;
    logic [EXT_CNT_W-1:0]  escan_reg, escan_next;
    logic [LIVE_IDX_W-1:0] slot_reg, slot_next;
    logic [LIVE_IDX_W-1:0] fslot_reg, fslot_next;
    logic                  slot_ok_reg, slot_ok_next;
    logic                  match_reg, match_next;
    logic                  out_valid_reg;
    ffea_out_t             out_reg, out_next;
    logic                  live_valid_reg [LIVE_BLOCKS];

    // live table memory, read registered at the scan address
    logic [32:0] live_off_mem [LIVE_BLOCKS];
    logic [32:0] live_len_mem [LIVE_BLOCKS];
    logic [32:0] live_off_rd, live_len_rd;
    logic        live_we;
    logic        live_clr;
    logic [LIVE_IDX_W-1:0] live_wa;
    logic [LIVE_IDX_W-1:0] chk;
    logic        chk_hit;

    // extent row
    ffea_ext_t ext_q    [FREE_EXTENTS];
    logic      ext_load [FREE_EXTENTS];
    ffea_ext_t ext_ld   [FREE_EXTENTS];
    logic      ext_shr, ext_shl;
    logic [EXT_IDX_W-1:0] ext_pos;
    logic [EXT_IDX_W-1:0] pos_reg, pos_next;

    logic        accept;
    logic [47:0] free_off;
    logic [32:0] sat_size;
    ffea_ext_t   cur;
    ffea_ext_t   prev;
    logic        nx_valid, mnext, mprev;
    logic [EXT_IDX_W-1:0] eidx;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign free_off  = in_data.block_address - base_reg;
    assign sat_size  = (cfg_data[32:0] > POOL_MAX) ? POOL_MAX : cfg_data[32:0];
    assign eidx      = escan_reg[EXT_IDX_W-1:0];
    assign cur       = ext_q[eidx];
    assign prev      = ext_q[eidx - 1'b1];

    // row of extent cells
    for (genvar g = 0; g < FREE_EXTENTS; g++)
    begin : g_cell
        ffea_ext_t left_d, right_d;
        logic      shr, shl;
        assign left_d  = (g == 0) ? ext_q[0] : ext_q[(g == 0) ? 0 : g - 1];
        assign right_d = (g == FREE_EXTENTS - 1) ? ext_q[g]
                                                 : ext_q[(g == FREE_EXTENTS - 1) ? g : g + 1];
        assign shr = ext_shr && (EXT_IDX_W'(g) > ext_pos);
        assign shl = ext_shl && (EXT_IDX_W'(g) >= ext_pos);
        ffea_cell u_cell (
            .clk        (clk),
            .load       (ext_load[g]),
            .load_data  (ext_ld[g]),
            .shift_right(shr),
            .shift_left (shl),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (ext_q[g])
        );
    end

    // live table read and write port
    always_ff @(posedge clk)
    begin
        live_off_rd <= live_off_mem[lscan_reg[LIVE_IDX_W-1:0]];
        live_len_rd <= live_len_mem[lscan_reg[LIVE_IDX_W-1:0]];
        if (live_we)
        begin
            live_off_mem[live_wa] <= off_reg;
            live_len_mem[live_wa] <= size_reg;
        end
    end

    // main sequencer
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        off_next     = off_reg;
        len_next     = len_reg;
        lscan_next   = lscan_reg;
        escan_next   = escan_reg;
        slot_next    = slot_reg;
        fslot_next   = fslot_reg;
        slot_ok_next = slot_ok_reg;
        match_next   = match_reg;
        pos_next     = pos_reg;
        out_next     = out_reg;
        live_we      = 1'b0;
        live_clr     = 1'b0;
        live_wa      = match_reg ? slot_reg : fslot_reg;
        ext_shr      = 1'b0;
        ext_shl      = 1'b0;
        ext_pos      = pos_reg;
        nx_valid     = escan_reg < count_reg;
        mnext        = 1'b0;
        mprev        = 1'b0;
        chk          = lscan_reg[LIVE_IDX_W-1:0] - 1'b1;
        chk_hit      = live_valid_reg[chk] && (live_off_rd == off_reg);
        for (int k = 0; k < FREE_EXTENTS; k++)
        begin
            ext_load[k] = 1'b0;
            ext_ld[k]   = ext_q[k];
        end
        case (state_reg)
            S_IDLE:
            begin
                lscan_next   = '0;
                escan_next   = '0;
                slot_next    = '0;
                fslot_next   = '0;
                slot_ok_next = 1'b0;
                match_next   = 1'b0;
                if (accept)
                begin
                    off_next = free_off[32:0];
                    len_next = '0;
                    if (in_data.command == CMD_ALLOC)
                        state_next = S_EXT;
                    else if (free_off[47:33] != '0)
                    begin
                        out_next   = '{granted_address: '0, status: ST_UNKNOWN};
                        state_next = S_DONE;
                    end
                    else
                        state_next = S_LIVE;
                end
            end
            S_LIVE:
            begin
                // slot lscan-1 is on the read port; note first match and first free slot
                if (lscan_reg != '0)
                begin
                    if (chk_hit && !match_reg)
                    begin
                        match_next = 1'b1;
                        slot_next  = chk;
                        len_next   = live_len_rd;
                    end
                    if (!live_valid_reg[chk] && !slot_ok_reg)
                    begin
                        slot_ok_next = 1'b1;
                        fslot_next   = chk;
                    end
                end
                if (lscan_reg == LIVE_CNT_W'(LIVE_BLOCKS))
                begin
                    if (cmd_reg == CMD_ALLOC)
                        state_next = S_SHIFT;
                    else if (match_next)
                        state_next = S_EXT;
                    else
                    begin
                        out_next   = '{granted_address: '0, status: ST_UNKNOWN};
                        state_next = S_DONE;
                    end
                end
                else
                    lscan_next = lscan_reg + 1'b1;
            end
            S_EXT:
            begin
                if (cmd_reg == CMD_ALLOC)
                begin
                    // first fit: lowest extent long enough
                    if (!nx_valid)
                    begin
                        out_next   = '{granted_address: '0, status: ST_EXHAUSTED};
                        state_next = S_DONE;
                    end
                    else if (cur.length >= size_reg)
                    begin
                        off_next   = cur.offset;
                        pos_next   = eidx;
                        state_next = S_LIVE;
                    end
                    else
                        escan_next = escan_reg + 1'b1;
                end
                else
                begin
                    // find first extent at or after the freed offset, then merge
                    if (nx_valid && cur.offset < off_reg)
                        escan_next = escan_reg + 1'b1;
                    else
                    begin
                        mnext = nx_valid && (off_reg + len_reg == cur.offset);
                        mprev = (escan_reg != '0) && (prev.offset + prev.length == off_reg);
                        state_next = S_DONE;
                        if (!mnext && !mprev && count_reg == EXT_CNT_W'(FREE_EXTENTS))
                            out_next = '{granted_address: '0, status: ST_FULL};
                        else
                        begin
                            out_next = '{granted_address: '0, status: ST_OK};
                            live_clr = 1'b1;
                            ext_pos  = eidx;
                            if (mprev && mnext)
                            begin
                                ext_load[eidx - 1'b1] = 1'b1;
                                ext_ld[eidx - 1'b1]   = '{offset: prev.offset,
                                    length: prev.length + len_reg + cur.length};
                                ext_shl    = 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                            else if (mprev)
                            begin
                                ext_load[eidx - 1'b1] = 1'b1;
                                ext_ld[eidx - 1'b1]   = '{offset: prev.offset,
                                    length: prev.length + len_reg};
                            end
                            else if (mnext)
                            begin
                                ext_load[eidx] = 1'b1;
                                ext_ld[eidx]   = '{offset: off_reg,
                                    length: cur.length + len_reg};
                            end
                            else if (len_reg != '0)
                            begin
                                // open a gap at the position and place the block there
                                ext_shr        = 1'b1;
                                ext_load[eidx] = 1'b1;
                                ext_ld[eidx]   = '{offset: off_reg, length: len_reg};
                                count_next     = count_reg + 1'b1;
                            end
                        end
                    end
                end
            end
            S_SHIFT:
            begin
                // commit the allocation: record the block, trim or drop the extent; full when no slot is free
                if (!slot_ok_reg && !match_reg)
                    out_next = '{granted_address: '0, status: ST_FULL};
                else
                begin
                    live_we  = 1'b1;
                    out_next = '{granted_address: base_reg + {15'd0, off_reg},
                                 status: ST_OK};
                    if (ext_q[pos_reg].length == size_reg)
                    begin
                        ext_shl    = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        ext_load[pos_reg] = 1'b1;
                        ext_ld[pos_reg]   = '{offset: off_reg + size_reg,
                            length: ext_q[pos_reg].length - size_reg};
                    end
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // pool size write loads one extent into slot 0 (none counted when the size is 0)
        if (cfg_we && cfg_index == REG_POOL_SIZE)
        begin
            count_next  = (sat_size != '0) ? EXT_CNT_W'(1) : '0;
            ext_load[0] = 1'b1;
            ext_ld[0]   = '{offset: '0, length: sat_size};
        end
    end

    // control state, registers and live bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < LIVE_BLOCKS; k++)
                live_valid_reg[k] <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == S_DONE)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_we && cfg_index == REG_POOL_BASE)
                base_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_POOL_SIZE)
            begin
                for (int k = 0; k < LIVE_BLOCKS; k++)
                    live_valid_reg[k] <= 1'b0;
            end
            else if (live_we)
                live_valid_reg[live_wa] <= 1'b1;
            else if (live_clr)
                live_valid_reg[slot_reg] <= 1'b0;
        end
    end

    // request payload and scan registers
    always_ff @(posedge clk)
    begin
        off_reg     <= off_next;
        len_reg     <= len_next;
        lscan_reg   <= lscan_next;
        escan_reg   <= escan_next;
        slot_reg    <= slot_next;
        fslot_reg   <= fslot_next;
        slot_ok_reg <= slot_ok_next;
        match_reg   <= match_next;
        pos_reg     <= pos_next;
        out_reg     <= out_next;
        if (accept)
        begin
            cmd_reg  <= in_data.command;
            size_reg <= ({1'b0, in_data.request_bytes} + GRAIN_MASK) & ~GRAIN_MASK;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= EXT_CNT_W'(FREE_EXTENTS))
        else $error("extent count beyond row length");
    a_one_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == S_IDLE)
        else $error("result held while request in flight");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid_reg)
        else $error("request taken with result pending");

endmodule

@@ src/ffea_cell.sv @@
// One slot of the sorted free-extent row. The slot can load, take a value
// from its left or right neighbour (shift for insert or remove) or hold.
module ffea_cell
    import ffea_pkg::*;
(
    input  logic      clk,
    input  logic      load,
    input  ffea_ext_t load_data,
    input  logic      shift_right,
    input  logic      shift_left,
    input  ffea_ext_t left_data,
    input  ffea_ext_t right_data,
    output ffea_ext_t data
);

    ffea_ext_t data_reg;
    ffea_ext_t data_next;

    // pick the next contents of the slot
    always_comb
    begin
        data_next = data_reg;
        if (load)
            data_next = load_data;
        else if (shift_right)
            data_next = left_data;
        else if (shift_left)
            data_next = right_data;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ verif/ffea_checker.sv @@
module ffea_checker
    import ffea_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  ffea_in_t    in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  ffea_out_t   out_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [47:0] cfg_data,
    output int          fail_count,
    output int          grants_waiting
);

    // shadow copy of the allocator state
    logic [47:0] base_addr;
    logic [32:0] pool_len;
    logic [32:0] ext_off [FREE_EXTENTS];
    logic [32:0] ext_len [FREE_EXTENTS];
    int          ext_cnt;
    logic [32:0] blk_off [LIVE_BLOCKS];
    logic [32:0] blk_len [LIVE_BLOCKS];
    logic        blk_used [LIVE_BLOCKS];

    ffea_out_t   grant_queue [$];

    function automatic void rebuild_pool();
        for (int k = 0; k < LIVE_BLOCKS; k++) blk_used[k] = 1'b0;
        ext_cnt = 0;
        if (pool_len != 0) begin
            ext_off[0] = '0;
            ext_len[0] = pool_len;
            ext_cnt    = 1;
        end
    endfunction

    function automatic void drop_extent(int i);
        for (int k = i; k + 1 < ext_cnt; k++) begin
            ext_off[k] = ext_off[k + 1];
            ext_len[k] = ext_len[k + 1];
        end
        ext_cnt--;
    endfunction

    function automatic void add_extent(int i, logic [32:0] o, logic [32:0] l);
        for (int k = ext_cnt; k > i; k--) begin
            ext_off[k] = ext_off[k - 1];
            ext_len[k] = ext_len[k - 1];
        end
        ext_off[i] = o;
        ext_len[i] = l;
        ext_cnt++;
    endfunction

    function automatic ffea_out_t grant_block(logic [31:0] req);
        ffea_out_t   r;
        logic [32:0] sz;
        logic [32:0] o;
        int          i;
        int          slot;
        int          hit;
        r    = '0;
        sz   = ({1'b0, req} + GRAIN_MASK) & ~GRAIN_MASK;
        slot = LIVE_BLOCKS;
        hit  = LIVE_BLOCKS;
        for (i = 0; i < ext_cnt; i++)
            if (ext_len[i] >= sz) break;
        if (i >= ext_cnt) begin
            r.status = ST_EXHAUSTED;
            return r;
        end
        o = ext_off[i];
        for (int k = 0; k < LIVE_BLOCKS; k++) begin
            if (blk_used[k]) begin
                if (blk_off[k] == o && hit == LIVE_BLOCKS) hit = k;
            end
            else if (slot == LIVE_BLOCKS) slot = k;
        end
        if (hit != LIVE_BLOCKS) slot = hit;
        if (slot == LIVE_BLOCKS) begin
            r.status = ST_FULL;
            return r;
        end
        if (ext_len[i] == sz) drop_extent(i);
        else
        begin
            ext_off[i] = o + sz;
            ext_len[i] = ext_len[i] - sz;
        end
        blk_off[slot]  = o;
        blk_len[slot]  = sz;
        blk_used[slot] = 1'b1;
        r.granted_address = base_addr + {15'd0, o};
        r.status = ST_OK;
        return r;
    endfunction

    function automatic ffea_out_t release_block(logic [47:0] addr);
        ffea_out_t   r;
        logic [47:0] o;
        logic [33:0] l;
        int          slot;
        int          nx;
        logic        join_next;
        logic        join_prev;
        r = '0;
        o = addr - base_addr;
        for (slot = 0; slot < LIVE_BLOCKS; slot++)
            if (blk_used[slot] && {15'd0, blk_off[slot]} == o) break;
        if (slot >= LIVE_BLOCKS) begin
            r.status = ST_UNKNOWN;
            return r;
        end
        l = {1'b0, blk_len[slot]};
        for (nx = 0; nx < ext_cnt; nx++)
            if ({15'd0, ext_off[nx]} >= o) break;
        join_next = nx < ext_cnt && ({1'b0, o[32:0]} + l) == {1'b0, ext_off[nx]};
        join_prev = nx > 0 && ({1'b0, ext_off[nx - 1]} + {1'b0, ext_len[nx - 1]}) == o[33:0];
        if (!join_next && !join_prev && ext_cnt >= FREE_EXTENTS) begin
            r.status = ST_FULL;
            return r;
        end
        blk_used[slot] = 1'b0;
        if (join_next) begin
            l = l + {1'b0, ext_len[nx]};
            drop_extent(nx);
        end
        if (join_prev) ext_len[nx - 1] = ext_len[nx - 1] + l[32:0];
        else if (l != 0) add_extent(nx, o[32:0], l[32:0]);
        r.status = ST_OK;
        return r;
    endfunction

    // track config, predict on each request, compare on each result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            base_addr  = '0;
            pool_len   = '0;
            fail_count = 0;
            ext_cnt    = 0;
            for (int k = 0; k < LIVE_BLOCKS; k++) blk_used[k] = 1'b0;
            grant_queue.delete();
        end
        else
        begin
            if (cfg_we) begin
                if (cfg_index == REG_POOL_BASE) base_addr = cfg_data;
                else
                begin
                    pool_len = (cfg_data[32:0] > POOL_MAX) ? POOL_MAX : cfg_data[32:0];
                    rebuild_pool();
                end
            end
            if (in_valid && in_ready) begin
                if (in_data.command == CMD_ALLOC)
                    grant_queue = {grant_queue, grant_block(in_data.request_bytes)};
                else
                    grant_queue = {grant_queue, release_block(in_data.block_address)};
            end
            if (out_valid && out_ready) begin
                if (grant_queue.size() == 0) begin
                    $display("%0t: unexpected result got %h", $realtime, out_data);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    ffea_out_t e;
                    e = grant_queue.pop_front();
                    if (e.granted_address != out_data.granted_address) begin
                        $display("%0t: granted_address expected %h got %h", $realtime,
                                 e.granted_address, out_data.granted_address);
                        fail_count = fail_count + 1;
                    end
                    if (e.status != out_data.status) begin
                        $display("%0t: status expected %0d got %0d", $realtime,
                                 e.status, out_data.status);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
        grants_waiting = grant_queue.size();
    end

endmodule

@@ verif/tb_first_fit_extent_allocator.sv @@
module tb_first_fit_extent_allocator
    import ffea_pkg::*;
();

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    ffea_in_t    in_data;
    logic        out_valid;
    logic        out_ready;
    ffea_out_t   out_data;
    logic        cfg_we;
    logic        cfg_index;
    logic [47:0] cfg_data;
    int          fail_count;
    int          grants_waiting;

    logic [47:0] held_addr [$];
    logic [47:0] cur_base;
    int          burst_left;

    first_fit_extent_allocator u_dut (.*);

    ffea_checker u_chk (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // stall the result side on a random pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_ready <= 1'b0;
        else
        begin
            case ($urandom_range(0, 3))
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                2: out_ready <= ($urandom_range(0, 1) != 0);
                default: out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // note granted addresses so later frees hit live blocks
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready && out_data.status == ST_OK &&
            out_data.granted_address != 0)
            held_addr = {held_addr, out_data.granted_address};
    end

    task automatic send_request(logic cmd, logic [31:0] bytes, logic [47:0] addr);
        ffea_in_t r;
        int       gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        r.command       = cmd;
        r.request_bytes = bytes;
        r.block_address = addr;
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (grants_waiting != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [47:0] val);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_POOL_BASE) cur_base = val;
        else held_addr.delete();
    endtask

    function automatic logic [31:0] pick_bytes();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 0;
            2: return $urandom_range(0, 255);
            default: return $urandom_range(1, 8) * 256 - $urandom_range(0, 300);
        endcase
    endfunction

    function automatic logic [47:0] pick_free_addr();
        int k;
        if (held_addr.size() != 0 && $urandom_range(0, 9) != 0) begin
            k = $urandom_range(0, held_addr.size() - 1);
            pick_free_addr = held_addr[k];
            held_addr.delete(k);
        end
        else if ($urandom_range(0, 1) != 0)
            pick_free_addr = 48'({$urandom, $urandom});
        else
            pick_free_addr = cur_base + 48'($urandom_range(0, 64) * 256);
    endfunction

    task automatic random_phase(int n, int alloc_bias);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < alloc_bias)
                send_request(CMD_ALLOC, pick_bytes(), 48'($urandom));
            else
                send_request(CMD_FREE, $urandom, pick_free_addr());
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_we     = 1'b0;
        cfg_index  = REG_POOL_BASE;
        cfg_data   = '0;
        cur_base   = '0;
        burst_left = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pool: every allocate is exhausted
        send_request(CMD_ALLOC, 0, 0);
        send_request(CMD_ALLOC, 32'hFFFF_FFFF, 0);
        send_request(CMD_FREE, 0, 48'hFFFF_FFFF_FFFF);

        // full-size pool at the top base: extremes, zero bytes, same offset twice
        write_reg(REG_POOL_BASE, 48'hFFFF_FFFF_FF00);
        write_reg(REG_POOL_SIZE, 48'h1_FFFF_FFFF);
        send_request(CMD_ALLOC, 0, 0);
        send_request(CMD_ALLOC, 32'hFFFF_FFFF, 0);
        send_request(CMD_ALLOC, 1, 0);
        send_request(CMD_FREE, 0, 48'hFFFF_FFFF_FF00);
        send_request(CMD_FREE, 0, 48'h0000_0000_0000);
        send_request(CMD_ALLOC, 255, 0);
        send_request(CMD_ALLOC, 256, 0);
        send_request(CMD_FREE, 0, 48'h0000_0000_0000);
        send_request(CMD_FREE, 0, 48'h1234_5678_9ABC);
        send_request(CMD_ALLOC, 32'hFFFF_FFFF, 0);

        // small pool: fill the live table, then free alternately to fill extents
        write_reg(REG_POOL_BASE, 48'h0000_0010_0000);
        write_reg(REG_POOL_SIZE, 48'd300 * 256);
        for (int i = 0; i < 70; i++) send_request(CMD_ALLOC, 256, 0);
        for (int i = 0; i < 64; i += 2)
            send_request(CMD_FREE, 0, cur_base + 48'(i * 256));
        send_request(CMD_FREE, 0, cur_base + 48'(1 * 256));
        send_request(CMD_FREE, 0, cur_base + 48'(63 * 256));

        // hold off until the allocator has answered everything
        drain_results();
        held_addr.delete();
        for (int i = 1; i < 64; i += 2) held_addr = {held_addr, cur_base + 48'(i * 256)};

        random_phase(350, 45);
        write_reg(REG_POOL_SIZE, 48'd16384);
        random_phase(400, 55);
        write_reg(REG_POOL_BASE, 48'({$urandom, $urandom}));
        write_reg(REG_POOL_SIZE, 48'd0);
        random_phase(30, 50);
        write_reg(REG_POOL_SIZE, 48'd40000);
        random_phase(450, 50);
        write_reg(REG_POOL_SIZE, 48'd2560);
        random_phase(300, 50);

        drain_results();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #30000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
